/* rtl/core/tli3d_pkg.sv */
// Shared types and constants for the timed 3-D linear interpolator.
// Used by the divider, the axis unit and the core; depends on nothing.
package tli3d_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned FactorW = 16;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned AxisW   = 2;

  localparam logic [1:0] PHASE_WAIT = 2'd0;
  localparam logic [1:0] PHASE_MOVE = 2'd1;
  localparam logic [1:0] PHASE_DONE = 2'd2;

  localparam logic [2:0] REG_START_DELAY   = 3'd0;
  localparam logic [2:0] REG_MOVE_DURATION = 3'd1;
  localparam logic [2:0] REG_DEST_X        = 3'd2;
  localparam logic [2:0] REG_DEST_Y        = 3'd3;
  localparam logic [2:0] REG_DEST_Z        = 3'd4;
  localparam logic [2:0] REG_ORIGIN_X      = 3'd5;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd6;
  localparam logic [2:0] REG_ORIGIN_Z      = 3'd7;

  typedef logic [1:0] axis_t;

  typedef struct packed {
    logic               valid;
    axis_t              axis;
    logic [CoordW-1:0]  start;
    logic [CoordW-1:0]  dest;
    logic [FactorW-1:0] factor;
  } lerp_req_t;

  typedef struct packed {
    logic              valid;
    axis_t             axis;
    logic [CoordW-1:0] pos;
  } lerp_rsp_t;

endpackage

/* rtl/core/timed_linear_interpolator_3d_core.sv */
// Top level of the timed 3-D linear interpolator: sequencer, registers and ports.
// Instantiates tli3d_div and tli3d_lerp; uses tli3d_pkg.
//
// Each request carries an elapsed tick count and a live source position and
// yields one result: a phase code in out_tuser and a Q16.16 position in
// out_tdata. Before start_delay the phase is waiting and the position is
// zero; from start_delay + move_duration on (a 33-bit sum, so it never
// wraps) the phase is done and the destination is returned. In between the
// fraction (elapsed - start_delay) / move_duration is found to sixteen bits
// by a serial divider and drives one shared multiply-add unit that treats the
// three axes in turn. With CAPTURE_START set, the start point is taken from
// the source on the first moving request after reset and held from then on;
// otherwise the origin registers are the start point. The block takes one
// request at a time. A waiting or done request has its result valid once
// S_SUM has formed the deadline and the offset and S_CLASS has classified
// the request. A moving request then waits in S_DIV for the divider
// (sixteen one-bit steps, then its done flag), S_ISSUE feeds the axes into
// the shared unit and S_DRAIN waits for its pipeline to drain. in_tready
// returns in the cycle after the result is taken, so a new request is
// accepted only once the previous result has been taken.
// Configuration is written through cfg_we, cfg_index and cfg_wdata and must
// only change while no request is in flight.
module timed_linear_interpolator_3d_core #(
  parameter int unsigned CAPTURE_START = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  // Request channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // elapsed_time, source_x, source_y, source_z
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // position_x, position_y, position_z
  output logic [1:0]   out_tuser,  // phase
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import tli3d_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_CLASS,
    S_DIV,
    S_ISSUE,
    S_DRAIN,
    S_OUT
  } state_t;

  // Configuration registers.
  logic [CoordW-1:0] start_delay_r, move_duration_r;
  logic [CoordW-1:0] dest_r   [NumAxes];
  logic [CoordW-1:0] origin_r [NumAxes];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delay_r   <= '0;
      move_duration_r <= '0;
      for (int i = 0; i < NumAxes; i++) begin
        dest_r[i]   <= '0;
        origin_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_DELAY:   start_delay_r   <= cfg_wdata;
        REG_MOVE_DURATION: move_duration_r <= cfg_wdata;
        REG_DEST_X:        dest_r[0]       <= cfg_wdata;
        REG_DEST_Y:        dest_r[1]       <= cfg_wdata;
        REG_DEST_Z:        dest_r[2]       <= cfg_wdata;
        REG_ORIGIN_X:      origin_r[0]     <= cfg_wdata;
        REG_ORIGIN_Y:      origin_r[1]     <= cfg_wdata;
        REG_ORIGIN_Z:      origin_r[2]     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer state and registered outputs.
  state_t             state_r;
  logic [CoordW-1:0]  time_r;
  logic [CoordW-1:0]  source_r  [NumAxes];
  logic [CoordW-1:0]  latched_r [NumAxes];
  logic               capture_pending_r;
  logic [CoordW:0]    deadline_r;
  logic [CoordW-1:0]  offset_r;
  logic               before_r;
  axis_t              issue_r;
  axis_t              got_r;
  logic [CoordW-1:0]  pos_r [NumAxes];
  logic [1:0]         phase_r;
  logic               out_valid_r;

  logic [CoordW:0]    offset_wide;
  logic               div_start;
  logic               div_done;
  logic [FactorW-1:0] factor;
  logic               capture_now;
  lerp_req_t          lreq;
  lerp_rsp_t          lrsp;

  // The subtraction's borrow tells a waiting request apart; the remainder
  // that seeds the divider is the same difference.
  assign offset_wide = {1'b0, time_r} - {1'b0, start_delay_r};
  assign div_start   = (state_r == S_CLASS) && !({1'b0, time_r} >= deadline_r) && !before_r;
  assign capture_now = div_start && (CAPTURE_START != 0) && capture_pending_r;

  tli3d_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (offset_r),
    .den   (move_duration_r),
    .done  (div_done),
    .quot  (factor)
  );

  // Axes are fed one per cycle; the start point is the latched source when
  // capturing and the origin register otherwise.
  always_comb begin
    lreq.valid  = (state_r == S_ISSUE);
    lreq.axis   = issue_r;
    lreq.start  = (CAPTURE_START != 0) ? latched_r[issue_r] : origin_r[issue_r];
    lreq.dest   = dest_r[issue_r];
    lreq.factor = factor;
  end

  tli3d_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lreq),
    .rsp   (lrsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      capture_pending_r <= 1'b1;
      out_valid_r       <= 1'b0;
      issue_r           <= '0;
      got_r             <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          state_r <= S_CLASS;
        end
        S_CLASS: begin
          issue_r <= '0;
          got_r   <= '0;
          if ({1'b0, time_r} >= deadline_r) begin
            phase_r     <= PHASE_DONE;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else if (before_r) begin
            phase_r     <= PHASE_WAIT;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            phase_r <= PHASE_MOVE;
            if (capture_now) begin
              capture_pending_r <= 1'b0;
            end
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          issue_r <= issue_r + AxisW'(1);
          if (issue_r == AxisW'(NumAxes - 1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (lrsp.valid) begin
            got_r <= got_r + AxisW'(1);
            if (got_r == AxisW'(NumAxes - 1)) begin
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      time_r      <= in_tdata[31:0];
      source_r[0] <= in_tdata[63:32];
      source_r[1] <= in_tdata[95:64];
      source_r[2] <= in_tdata[127:96];
    end
    if (state_r == S_SUM) begin
      deadline_r <= {1'b0, start_delay_r} + {1'b0, move_duration_r};
      offset_r   <= offset_wide[CoordW-1:0];
      before_r   <= offset_wide[CoordW];
    end
    if (capture_now) begin
      for (int i = 0; i < NumAxes; i++) begin
        latched_r[i] <= source_r[i];
      end
    end
    if (state_r == S_CLASS) begin
      for (int i = 0; i < NumAxes; i++) begin
        pos_r[i] <= ({1'b0, time_r} >= deadline_r) ? dest_r[i] : '0;
      end
    end
    if (state_r == S_DRAIN && lrsp.valid) begin
      pos_r[lrsp.axis] <= lrsp.pos;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = phase_r;
  assign out_tdata  = {pos_r[2], pos_r[1], pos_r[0]};

  // A result is never offered while a new request can be taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request accepted while a result is pending");

  // Waiting results carry a zero position.
  a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == PHASE_WAIT) |-> (out_tdata == '0))
    else $error("waiting result with a non-zero position");

  // The start capture happens once after reset and never re-arms.
  a_capture_once: assert property (@(posedge clk) disable iff (!rst_n)
    !capture_pending_r |=> !capture_pending_r)
    else $error("start capture re-armed");

  // The divider only finishes while the sequencer is waiting for it.
  a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its step");

endmodule

/* rtl/core/tli3d_div.sv */
// Serial restoring divider giving a Q0.16 fraction num/den with num < den.
// One quotient bit per cycle, sixteen steps per division. Uses tli3d_pkg.
module tli3d_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [tli3d_pkg::CoordW-1:0]     num,
  input  logic [tli3d_pkg::CoordW-1:0]     den,
  output logic                             done,
  output logic [tli3d_pkg::FactorW-1:0]    quot
);
  import tli3d_pkg::*;

  localparam int unsigned CntW = $clog2(FactorW);

  logic [CoordW-1:0]  rem_r, rem_nxt;
  logic [CoordW-1:0]  den_r;
  logic [FactorW-1:0] quot_r, quot_nxt;
  logic [CntW-1:0]    cnt_r;
  logic               busy_r, done_r;
  logic [CoordW:0]    shifted, trial;
  logic               ge;

  // One restoring step: the remainder stays below the divisor throughout.
  always_comb begin
    shifted  = {rem_r, 1'b0};
    trial    = shifted - {1'b0, den_r};
    ge       = !trial[CoordW];
    rem_nxt  = ge ? trial[CoordW-1:0] : shifted[CoordW-1:0];
    quot_nxt = {quot_r[FactorW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == CntW'(FactorW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* rtl/core/tli3d_lerp.sv */
// Three-stage axis unit: start + trunc((dest - start) * factor / 2^16).
// Shared by the three axes, one request per cycle. Uses tli3d_pkg.
module tli3d_lerp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tli3d_pkg::lerp_req_t  req,
  output tli3d_pkg::lerp_rsp_t  rsp
);
  import tli3d_pkg::*;

  localparam int unsigned ProdW = CoordW + 1 + FactorW;

  logic [CoordW:0]    diff, mag;
  logic               v1_r, v2_r, v3_r;
  axis_t              a1_r, a2_r, a3_r;
  logic               neg1_r, neg2_r;
  logic [CoordW:0]    mag_r;
  logic [FactorW-1:0] fac_r;
  logic [CoordW-1:0]  s1_r, s2_r, pos_r;
  logic [ProdW-1:0]   prod;
  logic [CoordW-1:0]  q_r;
  logic [CoordW-1:0]  delta;

  // Difference of two signed values needs one extra bit; the product is
  // formed on the magnitude so that the shift truncates toward zero.
  always_comb begin
    diff  = {req.dest[CoordW-1], req.dest} - {req.start[CoordW-1], req.start};
    mag   = diff[CoordW] ? (~diff + (CoordW+1)'(1)) : diff;
    prod  = ProdW'(mag_r) * ProdW'(fac_r);
    delta = neg2_r ? (~q_r + CoordW'(1)) : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r   <= req.axis;
    neg1_r <= diff[CoordW];
    mag_r  <= mag;
    fac_r  <= req.factor;
    s1_r   <= req.start;

    a2_r   <= a1_r;
    neg2_r <= neg1_r;
    s2_r   <= s1_r;
    q_r    <= prod[FactorW +: CoordW];

    a3_r   <= a2_r;
    pos_r  <= s2_r + delta;
  end

  assign rsp.valid = v3_r;
  assign rsp.axis  = a3_r;
  assign rsp.pos   = pos_r;

endmodule
